// ===== src/tcpaft_pkg.sv =====
// tcp active flow tracker: shared types and constants
// no dependencies
package tcpaft_pkg;

    localparam int TIME_W  = 56;
    localparam int KEY_W   = 96;
    localparam int PKT_W   = 48;
    localparam int CNT_W   = 11;

    localparam logic [TIME_W-1:0] IDLE_RESET   = 56'd5000000;
    localparam logic [TIME_W-1:0] SCAN_RESET   = 56'd100000;
    localparam logic [TIME_W-1:0] REPORT_RESET = 56'd1000000;
    localparam logic [TIME_W-1:0] SYN_STAMP    = 56'd1;

    localparam logic [1:0] REG_IDLE   = 2'd0;
    localparam logic [1:0] REG_SCAN   = 2'd1;
    localparam logic [1:0] REG_REPORT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } state_t;

    // comparison request to the shared time unit
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] then_t;
        logic [TIME_W-1:0] limit;
    } cmp_req_t;

endpackage

// ===== src/tcpaft_elapsed.sv =====
// shared elapsed-time comparator: (now - then) mod 2^56 > limit
// depends on tcpaft_pkg
module tcpaft_elapsed (
    input  tcpaft_pkg::cmp_req_t req,
    output logic                 over
);
    import tcpaft_pkg::*;

    logic [TIME_W-1:0] diff;

    always_comb
    begin
        diff = req.now - req.then_t;
        over = diff > req.limit;
    end
endmodule

// ===== src/tcp_active_flow_tracker.sv =====
// tcp active flow tracker: flow table with idle timeout, one packet per request
// tcp requests walk the table for a match and a free entry; a due timeout scan walks it
// again through the shared elapsed comparator. the table walk reads one entry a cycle
// through the single read port. a new request is taken only in idle, once the last result
// has moved to the output register. reset: counters, times and registers at once, then a
// clearing pass over the valid bits
module tcp_active_flow_tracker #(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [55:0] timestamp_us,
    input  logic        is_tcp,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic        syn_bit,
    input  logic        fin_bit,
    input  logic        rst_bit,
    input  logic [15:0] payload_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        report_due,
    output logic [10:0] active_flows,
    output logic [47:0] packet_total,
    output logic [55:0] byte_total,
    output logic [10:0] expired_count,
    output logic        table_full,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [55:0] cfg_data
);
    import tcpaft_pkg::*;

    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(FLOW_ENTRIES - 1);

    // table storage; valid bits cleared by a pass after reset, rest undefined until written
    logic                 valid_mem [FLOW_ENTRIES];
    logic [KEY_W-1:0]     key_mem  [FLOW_ENTRIES];
    logic [TIME_W-1:0]    seen_mem [FLOW_ENTRIES];

    state_t state_reg, state_next;
    logic [TIME_W-1:0] idle_reg, scan_reg, report_reg;
    logic [TIME_W-1:0] last_rep_reg, last_scan_reg;
    logic [PKT_W-1:0]  pkt_reg;
    logic [TIME_W-1:0] byte_reg;
    logic [IDX_W:0]    flows_reg;
    logic [IDX_W:0]    exp_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              issue_reg;

    // captured packet
    logic [TIME_W-1:0] ts_reg;
    logic [KEY_W-1:0]  pkey_reg;
    logic              tcp_reg, syn_reg, rem_reg;
    logic              hit_reg, free_found_reg, full_reg, rep_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg;

    // registered table reads
    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_seen_reg;
    logic              rd_valid_reg, rd_live_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    // result register, frees the datapath while a result waits
    logic              out_valid_reg;
    logic              rep_out_reg, full_out_reg;
    logic [CNT_W-1:0]  act_out_reg, exp_out_reg;
    logic [PKT_W-1:0]  pkt_out_reg;
    logic [TIME_W-1:0] byte_out_reg;
    logic              out_load;

    cmp_req_t cmp_req;
    logic     cmp_over;

    tcpaft_elapsed u_cmp (.req(cmp_req), .over(cmp_over));

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign report_due    = rep_out_reg;
    assign table_full    = full_out_reg;
    assign packet_total  = pkt_out_reg;
    assign byte_total    = byte_out_reg;
    assign active_flows  = act_out_reg;
    assign expired_count = exp_out_reg;

    // result moves to the output when the output is empty or being taken
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // shared comparator: report test in update, scan test in check, idle test during scan
    always_comb
    begin
        cmp_req.now = ts_reg;
        if (state_reg == ST_SCAN) begin
            cmp_req.then_t = rd_seen_reg;
            cmp_req.limit  = idle_reg;
        end else if (state_reg == ST_UPDATE) begin
            cmp_req.then_t = last_rep_reg;
            cmp_req.limit  = report_reg;
        end else begin
            cmp_req.then_t = last_scan_reg;
            cmp_req.limit  = scan_reg;
        end
    end

    // last entry of a walk has come back from the table
    logic look_end;
    assign look_end = rd_live_reg && (rd_idx_reg == LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (idx_reg == LAST) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = is_tcp ? ST_LOOK : ST_UPDATE;
            ST_LOOK:   if (look_end) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CHECK;
            ST_CHECK:  state_next = cmp_over ? ST_SCAN : ST_DONE;
            ST_SCAN:   if (look_end) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    logic expire_now;
    assign expire_now = (state_reg == ST_SCAN) && rd_live_reg && rd_valid_reg && cmp_over;

    // single write port of the valid bits
    logic             vwr_en;
    logic [IDX_W-1:0] vwr_idx;
    logic             vwr_data;

    always_comb
    begin
        vwr_en   = 1'b0;
        vwr_idx  = idx_reg;
        vwr_data = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vwr_en = 1'b1;
            end
            ST_UPDATE:
            begin
                if (tcp_reg && hit_reg && rem_reg) begin
                    vwr_en  = 1'b1;
                    vwr_idx = hit_idx_reg;
                end else if (tcp_reg && !hit_reg && !rem_reg && free_found_reg) begin
                    vwr_en   = 1'b1;
                    vwr_idx  = free_idx_reg;
                    vwr_data = 1'b1;
                end
            end
            ST_SCAN:
            begin
                vwr_en  = expire_now;
                vwr_idx = rd_idx_reg;
            end
            default: ;
        endcase
    end

    // table read port, one entry per cycle
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_mem[idx_reg];
        rd_key_reg   <= key_mem[idx_reg];
        rd_seen_reg  <= seen_mem[idx_reg];
        rd_idx_reg   <= idx_reg;
        if (vwr_en)
            valid_mem[vwr_idx] <= vwr_data;
    end

    logic wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  wr_key;
    logic [TIME_W-1:0] wr_seen;
    logic              wr_key_en;

    always_comb
    begin
        wr_en     = 1'b0;
        wr_key_en = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_key    = pkey_reg;
        wr_seen   = syn_reg ? SYN_STAMP : ts_reg;
        if (state_reg == ST_UPDATE && tcp_reg && !rem_reg) begin
            if (hit_reg) begin
                wr_en = 1'b1;
            end else if (free_found_reg) begin
                wr_en     = 1'b1;
                wr_key_en = 1'b1;
                wr_idx    = free_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            seen_mem[wr_idx] <= wr_seen;
        if (wr_key_en)
            key_mem[wr_idx] <= wr_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idle_reg      <= IDLE_RESET;
            scan_reg      <= SCAN_RESET;
            report_reg    <= REPORT_RESET;
            last_rep_reg  <= '0;
            last_scan_reg <= '0;
            pkt_reg       <= '0;
            byte_reg      <= '0;
            flows_reg     <= '0;
            exp_reg       <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            rd_live_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            full_reg      <= 1'b0;
            rep_reg       <= 1'b0;
            tcp_reg       <= 1'b0;
            syn_reg       <= 1'b0;
            rem_reg       <= 1'b0;
            ts_reg        <= '0;
            pkey_reg      <= '0;
            hit_idx_reg   <= '0;
            free_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            rep_out_reg   <= 1'b0;
            full_out_reg  <= 1'b0;
            act_out_reg   <= '0;
            exp_out_reg   <= '0;
            pkt_out_reg   <= '0;
            byte_out_reg  <= '0;
        end else begin
            // read data is live in the cycle after its address was issued
            rd_live_reg   <= issue_reg;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    // clear one valid bit a cycle
                    if (idx_reg != LAST)
                        idx_reg <= idx_reg + 1'b1;
                    else
                        idx_reg <= '0;
                end
                ST_IDLE:
                begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            REG_IDLE:   idle_reg   <= cfg_data;
                            REG_SCAN:   scan_reg   <= cfg_data;
                            REG_REPORT: report_reg <= cfg_data;
                            default:    ;
                        endcase
                    end
                    if (in_valid) begin
                        ts_reg   <= timestamp_us;
                        pkey_reg <= {source_address, destination_address,
                                     source_port, destination_port};
                        tcp_reg  <= is_tcp;
                        syn_reg  <= syn_bit;
                        rem_reg  <= !syn_bit && (fin_bit || rst_bit);
                        if (pkt_reg != {PKT_W{1'b1}})
                            pkt_reg <= pkt_reg + 1'b1;
                        if (byte_reg > ({TIME_W{1'b1}} - TIME_W'(payload_length)))
                            byte_reg <= {TIME_W{1'b1}};
                        else
                            byte_reg <= byte_reg + TIME_W'(payload_length);
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        full_reg       <= 1'b0;
                        exp_reg        <= '0;
                        idx_reg        <= '0;
                        issue_reg      <= is_tcp;
                    end
                end
                ST_LOOK:
                begin
                    // walk the table, first match and first free entry
                    if (issue_reg) begin
                        if (idx_reg != LAST)
                            idx_reg <= idx_reg + 1'b1;
                        else
                            issue_reg <= 1'b0;
                    end
                    if (rd_live_reg) begin
                        if (rd_valid_reg) begin
                            if (!hit_reg && rd_key_reg == pkey_reg) begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= rd_idx_reg;
                            end
                        end else if (!free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    if (tcp_reg) begin
                        if (hit_reg && rem_reg) begin
                            flows_reg <= flows_reg - 1'b1;
                        end else if (!hit_reg && !rem_reg) begin
                            if (free_found_reg)
                                flows_reg <= flows_reg + 1'b1;
                            else
                                full_reg <= 1'b1;
                        end
                    end
                    rep_reg <= cmp_over;
                    if (cmp_over)
                        last_rep_reg <= ts_reg;
                end
                ST_CHECK:
                begin
                    // scan interval test, then start the walk if due
                    if (cmp_over) begin
                        last_scan_reg <= ts_reg;
                        idx_reg       <= '0;
                        issue_reg     <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (issue_reg) begin
                        if (idx_reg != LAST)
                            idx_reg <= idx_reg + 1'b1;
                        else
                            issue_reg <= 1'b0;
                    end
                    if (expire_now)
                        exp_reg <= exp_reg + 1'b1;
                end
                ST_DONE:
                begin
                    if (out_load) begin
                        rep_out_reg  <= rep_reg;
                        full_out_reg <= full_reg;
                        act_out_reg  <= CNT_W'(flows_reg);
                        exp_out_reg  <= CNT_W'(exp_reg);
                        pkt_out_reg  <= pkt_reg;
                        byte_out_reg <= byte_reg;
                        flows_reg    <= flows_reg - exp_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== tb/sv/tb_tcp_active_flow_tracker.sv =====
// testbench for tcp_active_flow_tracker: directed and random packet requests
// checked against an in-bench flow table predictor; depends on tcpaft_pkg and the rtl
module tb_tcp_active_flow_tracker;
    import tcpaft_pkg::*;

    localparam int ENTRIES    = 1024;
    localparam int POOL       = 48;
    localparam int FILL_FLOWS = 1060;
    localparam int DRAIN_WAIT = 2 * ENTRIES + 16;
    localparam int CYCLE_CAP  = 40000000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] ts;
        logic              tcp;
        logic [31:0]       saddr;
        logic [31:0]       daddr;
        logic [15:0]       sport;
        logic [15:0]       dport;
        logic              syn;
        logic              fin;
        logic              rst;
        logic [15:0]       len;
    } packet_t;

    typedef struct packed {
        logic              report;
        logic [CNT_W-1:0]  active;
        logic [PKT_W-1:0]  packets;
        logic [TIME_W-1:0] bytes;
        logic [CNT_W-1:0]  expired;
        logic              full;
    } stats_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    packet_t drv;
    logic out_valid;
    logic out_stall;
    logic report_due;
    logic [10:0] active_flows;
    logic [47:0] packet_total;
    logic [55:0] byte_total;
    logic [10:0] expired_count;
    logic table_full;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [55:0] cfg_data;

    tcp_active_flow_tracker #(.FLOW_ENTRIES(ENTRIES)) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .timestamp_us        (drv.ts),
        .is_tcp              (drv.tcp),
        .source_address      (drv.saddr),
        .destination_address (drv.daddr),
        .source_port         (drv.sport),
        .destination_port    (drv.dport),
        .syn_bit             (drv.syn),
        .fin_bit             (drv.fin),
        .rst_bit             (drv.rst),
        .payload_length      (drv.len),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .report_due          (report_due),
        .active_flows        (active_flows),
        .packet_total        (packet_total),
        .byte_total          (byte_total),
        .expired_count       (expired_count),
        .table_full          (table_full),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // clock: period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of the flow table, counters and registers
    logic              flow_live [ENTRIES];
    logic [63:0]       flow_addr [ENTRIES];
    logic [31:0]       flow_port [ENTRIES];
    logic [TIME_W-1:0] flow_seen [ENTRIES];
    int                live_flows;
    logic [PKT_W-1:0]  pkt_count;
    logic [TIME_W-1:0] byte_count;
    logic [TIME_W-1:0] last_report;
    logic [TIME_W-1:0] last_scan;
    logic [TIME_W-1:0] idle_limit;
    logic [TIME_W-1:0] scan_gap;
    logic [TIME_W-1:0] report_gap;

    packet_t pending_packets [$];
    stats_t  expected_stats  [$];

    int  errors;
    int  cycle;
    bit  req_taken;

    // key pool so that flows get refreshed, closed and expired
    logic [31:0] pool_saddr [POOL];
    logic [31:0] pool_daddr [POOL];
    logic [15:0] pool_sport [POOL];
    logic [15:0] pool_dport [POOL];
    logic [31:0] fill_saddr [FILL_FLOWS];
    logic [31:0] fill_daddr [FILL_FLOWS];
    logic [15:0] fill_sport [FILL_FLOWS];
    logic [15:0] fill_dport [FILL_FLOWS];
    logic [TIME_W-1:0] now_ts;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, field, got, want);
        errors++;
    endtask

    // one packet through the flow table, scan and counters
    task automatic track_packet(input packet_t p, output stats_t r);
        logic [63:0] addr;
        logic [31:0] ports;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] idle_for;
        logic drop;
        int hit;
        int free_slot;
        addr = {p.saddr, p.daddr};
        ports = {p.sport, p.dport};
        drop = !p.syn && (p.fin || p.rst);
        stamp = p.syn ? SYN_STAMP : p.ts;
        hit = -1;
        free_slot = -1;
        r = '0;
        if (pkt_count != {PKT_W{1'b1}})
            pkt_count++;
        if (byte_count > TIME_MAX - TIME_W'(p.len))
            byte_count = TIME_MAX;
        else
            byte_count = byte_count + TIME_W'(p.len);
        if (p.tcp)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (flow_live[i])
                begin
                    if (hit < 0 && flow_addr[i] == addr && flow_port[i] == ports)
                        hit = i;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (hit >= 0)
            begin
                if (drop)
                begin
                    flow_live[hit] = 1'b0;
                    live_flows--;
                end
                else
                    flow_seen[hit] = stamp;
            end
            else if (!drop)
            begin
                if (free_slot >= 0)
                begin
                    flow_live[free_slot] = 1'b1;
                    flow_addr[free_slot] = addr;
                    flow_port[free_slot] = ports;
                    flow_seen[free_slot] = stamp;
                    live_flows++;
                end
                else
                    r.full = 1'b1;
            end
        end
        r.active = CNT_W'(live_flows);
        // differences wrap at 56 bits, so a step back in time counts as elapsed
        if (TIME_W'(p.ts - last_report) > report_gap)
        begin
            last_report = p.ts;
            r.report = 1'b1;
        end
        if (TIME_W'(p.ts - last_scan) > scan_gap)
        begin
            last_scan = p.ts;
            for (int i = 0; i < ENTRIES; i++)
            begin
                idle_for = p.ts - flow_seen[i];
                if (flow_live[i] && idle_for > idle_limit)
                begin
                    flow_live[i] = 1'b0;
                    live_flows--;
                    r.expired++;
                end
            end
        end
        r.packets = pkt_count;
        r.bytes = byte_count;
    endtask

    // no idling in a long stretch in the middle of the run
    function automatic bit take_break();
        if (cycle > 300000 && cycle < 1200000)
            return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // request driver, changes inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken || !in_valid)
            begin
                req_taken = 1'b0;
                if (pending_packets.size() != 0 && !take_break())
                begin
                    drv <= pending_packets.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= take_break();
        end
    end

    // acceptance, prediction and result checking at the rising edge
    always @(posedge clk)
    begin
        stats_t want;
        stats_t got;
        cycle++;
        if (cycle > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IDLE:   idle_limit = cfg_data;
                REG_SCAN:   scan_gap = cfg_data;
                REG_REPORT: report_gap = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && in_valid && !in_stall)
        begin
            track_packet(drv, want);
            expected_stats.insert(expected_stats.size(), want);
            req_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{report_due, active_flows, packet_total, byte_total, expired_count,
                    table_full};
            if (expected_stats.size() == 0)
                report_mismatch("unexpected result", 64'(packet_total), 64'd0);
            else
            begin
                want = expected_stats.pop_front();
                if (got.report != want.report)
                    report_mismatch("report_due", 64'(got.report), 64'(want.report));
                if (got.active != want.active)
                    report_mismatch("active_flows", 64'(got.active), 64'(want.active));
                if (got.packets != want.packets)
                    report_mismatch("packet_total", 64'(got.packets), 64'(want.packets));
                if (got.bytes != want.bytes)
                    report_mismatch("byte_total", 64'(got.bytes), 64'(want.bytes));
                if (got.expired != want.expired)
                    report_mismatch("expired_count", 64'(got.expired), 64'(want.expired));
                if (got.full != want.full)
                    report_mismatch("table_full", 64'(got.full), 64'(want.full));
            end
        end
    end

    task automatic queue_packet(input logic [TIME_W-1:0] ts, input logic tcp,
                                input logic [31:0] sa, input logic [31:0] da,
                                input logic [15:0] sp, input logic [15:0] dp,
                                input logic syn, input logic fin, input logic rst,
                                input logic [15:0] len);
        packet_t p;
        p = '{ts, tcp, sa, da, sp, dp, syn, fin, rst, len};
        pending_packets.insert(pending_packets.size(), p);
    endtask

    task automatic queue_pool(input int k, input logic [TIME_W-1:0] ts,
                              input logic syn, input logic fin, input logic rst);
        queue_packet(ts, 1'b1, pool_saddr[k], pool_daddr[k], pool_sport[k], pool_dport[k],
                     syn, fin, rst, 16'($urandom));
    endtask

    // mostly pool flows with random flags, some fresh keys, non-tcp and time steps back
    task automatic queue_mixed(input int count, input int step_max);
        int roll;
        int k;
        logic [15:0] len;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                now_ts = now_ts - TIME_W'($urandom_range(1, 200));
            else if (roll < 5)
                now_ts = now_ts + TIME_W'($urandom_range(0, 40 * step_max));
            else
                now_ts = now_ts + TIME_W'($urandom_range(0, step_max));
            roll = $urandom_range(0, 9);
            len = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hffff : 16'($urandom);
            if ($urandom_range(0, 99) < 10)
                queue_packet(now_ts, 1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                             1'($urandom), 1'($urandom), 1'($urandom), len);
            else if ($urandom_range(0, 99) < 15)
                queue_packet(now_ts, 1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom),
                             1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 5) == 0),
                             1'($urandom_range(0, 7) == 0), len);
            else
            begin
                k = $urandom_range(0, POOL - 1);
                queue_packet(now_ts, 1'b1, pool_saddr[k], pool_daddr[k], pool_sport[k],
                             pool_dport[k], 1'($urandom_range(0, 6) == 0),
                             1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 19) == 0), len);
            end
        end
    endtask

    // every queued request answered, then room for a full scan in flight
    task automatic wait_idle();
        while (pending_packets.size() != 0 || in_valid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [TIME_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [TIME_W-1:0] idle_v, input logic [TIME_W-1:0] scan_v,
                             input logic [TIME_W-1:0] report_v);
        write_reg(REG_IDLE, idle_v);
        write_reg(REG_SCAN, scan_v);
        write_reg(REG_REPORT, report_v);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        drv = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IDLE;
        cfg_data = '0;
        errors = 0;
        cycle = 0;
        req_taken = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            flow_live[i] = 1'b0;
            flow_addr[i] = '0;
            flow_port[i] = '0;
            flow_seen[i] = '0;
        end
        live_flows = 0;
        pkt_count = '0;
        byte_count = '0;
        last_report = '0;
        last_scan = '0;
        idle_limit = IDLE_RESET;
        scan_gap = SCAN_RESET;
        report_gap = REPORT_RESET;
        for (int k = 0; k < POOL; k++)
        begin
            pool_saddr[k] = $urandom;
            pool_daddr[k] = $urandom;
            pool_sport[k] = 16'($urandom);
            pool_dport[k] = 16'($urandom);
        end
        // extreme keys: all zeros and all ones
        {pool_saddr[2], pool_daddr[2], pool_sport[2], pool_dport[2]} = '0;
        {pool_saddr[3], pool_daddr[3], pool_sport[3], pool_dport[3]} = '1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part with the reset register values
        queue_packet(56'd0, 1'b0, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, 16'd0);
        queue_pool(0, 56'd10, 1'b1, 1'b0, 1'b0);   // syn insert, stamp one
        queue_pool(0, 56'd20, 1'b0, 1'b0, 1'b0);   // refresh
        queue_pool(1, 56'd30, 1'b0, 1'b1, 1'b0);   // fin for an unknown flow
        queue_pool(1, 56'd35, 1'b0, 1'b0, 1'b1);   // rst for an unknown flow
        queue_pool(0, 56'd40, 1'b1, 1'b1, 1'b0);   // syn wins over fin
        queue_pool(1, 56'd50, 1'b1, 1'b0, 1'b1);   // syn wins over rst
        queue_pool(1, 56'd60, 1'b0, 1'b0, 1'b1);   // rst removes
        queue_pool(0, 56'd70, 1'b0, 1'b1, 1'b0);   // fin removes
        queue_pool(2, 56'd1000, 1'b0, 1'b0, 1'b0);
        queue_pool(3, 56'd1001, 1'b0, 1'b0, 1'b0);
        queue_packet(56'd100000, 1'b1, pool_saddr[4], pool_daddr[4], pool_sport[4],
                     pool_dport[4], 1'b0, 1'b0, 1'b0, 16'hffff);
        queue_pool(5, 56'd100001, 1'b0, 1'b0, 1'b0); // first scan
        queue_pool(6, 56'd1000000, 1'b1, 1'b0, 1'b0);
        queue_pool(6, 56'd1000001, 1'b0, 1'b0, 1'b0); // first report
        queue_pool(7, 56'd7000000, 1'b0, 1'b0, 1'b0); // scan expires stale flows
        queue_pool(8, TIME_MAX, 1'b0, 1'b0, 1'b0);    // top of the time range
        queue_pool(9, 56'd5, 1'b0, 1'b0, 1'b0);       // time goes back, wraps
        queue_packet(56'd6, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 16'hffff);
        wait_idle();

        // smallest intervals: scans and reports on nearly every packet
        write_all(56'd1, 56'd1, 56'd1);
        now_ts = 56'd100;
        queue_mixed(300, 3);
        wait_idle();

        // largest intervals: nothing expires, fill the table until inserts drop
        write_all(TIME_MAX, TIME_MAX, TIME_MAX);
        for (int n = 0; n < FILL_FLOWS; n++)
        begin
            fill_saddr[n] = $urandom;
            fill_daddr[n] = $urandom;
            fill_sport[n] = 16'($urandom);
            fill_dport[n] = 16'($urandom);
            now_ts = now_ts + TIME_W'($urandom_range(0, 5));
            queue_packet(now_ts, 1'b1, fill_saddr[n], fill_daddr[n], fill_sport[n],
                         fill_dport[n], 1'($urandom_range(0, 9) == 0), 1'b0, 1'b0,
                         16'($urandom));
        end
        queue_mixed(30, 5);
        // free a few entries and refill them
        for (int n = 0; n < 10; n++)
            queue_packet(now_ts, 1'b1, fill_saddr[n], fill_daddr[n], fill_sport[n],
                         fill_dport[n], 1'b0, 1'(n % 2), 1'(1 - n % 2), 16'd0);
        queue_mixed(20, 5);
        wait_idle();

        // middle settings: the full table ages out over time
        write_all(56'd2000, 56'd500, 56'd3000);
        queue_mixed(320, 60);
        wait_idle();

        // back to the reset values
        write_all(IDLE_RESET, SCAN_RESET, REPORT_RESET);
        queue_mixed(40, 200000);
        wait_idle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tcpaft_pkg.sv
src/tcpaft_elapsed.sv
src/tcp_active_flow_tracker.sv
tb/sv/tb_tcp_active_flow_tracker.sv
